[rtl/core/mtsl_pkg.sv]
// Shared types and constants of the two-list merge block.
package mtsl_pkg;

  localparam int unsigned MaxListDefault = 16;
  localparam int unsigned LenW           = 5;
  localparam int unsigned ValW           = 32;

  typedef logic [LenW-1:0]        len_t;
  typedef logic signed [ValW-1:0] val_t;

  localparam len_t LenReset = len_t'(16);

  // list_select codes
  localparam logic ListFirst  = 1'b0;
  localparam logic ListSecond = 1'b1;

  typedef struct packed {
    logic list_select;
    val_t value;
  } in_word_t;

  typedef struct packed {
    val_t merged_value;
    logic last;
  } out_word_t;

endpackage

[rtl/core/mtsl_stream_if.sv]
// Valid/ready channel interface carrying one word of type T.
interface mtsl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/mtsl_store.sv]
// One list store: synchronous RAM, one write port, one registered read port.
module mtsl_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  mtsl_pkg::val_t       wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output mtsl_pkg::val_t       rdata_o
);
  import mtsl_pkg::*;

  val_t mem [DEPTH];
  val_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mtsl_ctrl.sv]
// Load/merge sequencer: counts, read pointers, length register, output register.
module mtsl_ctrl #(
  parameter int unsigned MAX_LIST = mtsl_pkg::MaxListDefault,
  parameter int unsigned AW       = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_valid_i,
  input  mtsl_pkg::len_t      cfg_data_i,
  output logic                cfg_ready_o,
  // input words
  input  logic                in_valid_i,
  input  mtsl_pkg::in_word_t  in_word_i,
  output logic                in_ready_o,
  // output words
  output logic                out_valid_o,
  output mtsl_pkg::out_word_t out_word_o,
  input  logic                out_ready_i,
  // store ports
  output logic                a_we_o,
  output logic                b_we_o,
  output logic [AW-1:0]       waddr_a_o,
  output logic [AW-1:0]       waddr_b_o,
  output mtsl_pkg::val_t      wdata_o,
  output logic [AW-1:0]       raddr_a_o,
  output logic [AW-1:0]       raddr_b_o,
  input  mtsl_pkg::val_t      rdata_a_i,
  input  mtsl_pkg::val_t      rdata_b_i
);
  import mtsl_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_LIST + 1);
  localparam int unsigned CmpW = (CW > LenW) ? CW : LenW;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_PRIME = 3'b010,
    ST_MERGE = 3'b100
  } state_e;

  state_e         state_q, state_d;
  len_t           len_q;
  logic [CW-1:0]  n;
  logic [CW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]  ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic           out_valid_q;
  out_word_t      out_word_q;
  logic           in_acc, emit, take_a, is_last;
  logic [CmpW-1:0] len_ext;
  logic [CW:0]    pos_sum, twice_n;

  // effective length: 0 acts as 1, above MAX_LIST clamps
  assign len_ext = CmpW'(len_q);
  always_comb begin
    if (len_q == '0) begin
      n = CW'(1);
    end else if (len_ext > CmpW'(MAX_LIST)) begin
      n = CW'(MAX_LIST);
    end else begin
      n = CW'(len_ext);
    end
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;

  // loading writes
  assign a_we_o    = in_acc && (in_word_i.list_select == ListFirst)  && (cnt_a_q < n);
  assign b_we_o    = in_acc && (in_word_i.list_select == ListSecond) && (cnt_b_q < n);
  assign waddr_a_o = cnt_a_q[AW-1:0];
  assign waddr_b_o = cnt_b_q[AW-1:0];
  assign wdata_o   = in_word_i.value;

  // merge step: second list wins ties
  assign take_a  = (ptr_a_q < n) && ((ptr_b_q >= n) || (rdata_a_i < rdata_b_i));
  assign emit    = (state_q == ST_MERGE) && (!out_valid_q || out_ready_i);
  assign pos_sum = (CW+1)'(ptr_a_q) + (CW+1)'(ptr_b_q) + (CW+1)'(1);
  assign twice_n = (CW+1)'(n) << 1;
  assign is_last = (pos_sum == twice_n);

  always_comb begin
    state_d = state_q;
    cnt_a_d = cnt_a_q + CW'(a_we_o);
    cnt_b_d = cnt_b_q + CW'(b_we_o);
    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && (cnt_a_d >= n) && (cnt_b_d >= n)) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (emit) begin
          if (take_a) begin
            ptr_a_d = ptr_a_q + CW'(1);
          end else begin
            ptr_b_d = ptr_b_q + CW'(1);
          end
          if (is_last) begin
            state_d = ST_LOAD;
            cnt_a_d = '0;
            cnt_b_d = '0;
            ptr_a_d = '0;
            ptr_b_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // reads follow the next pointer so the registered heads line up with the pointers
  assign raddr_a_o = ptr_a_d[AW-1:0];
  assign raddr_b_o = ptr_b_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ptr_a_q <= ptr_a_d;
      ptr_b_q <= ptr_b_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q.merged_value <= take_a ? rdata_a_i : rdata_b_i;
      out_word_q.last         <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // stores are only written while loading
  a_wr_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_we_o || b_we_o) |-> (state_q == ST_LOAD))
    else $error("store write outside load phase");

  // read pointers stay within the effective length during a merge
  ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> ((ptr_a_q <= n) && (ptr_b_q <= n) && (pos_sum <= twice_n)))
    else $error("merge pointer beyond list length");

  // final word returns the block to loading with cleared counts
  last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> ((state_q == ST_LOAD) && (cnt_a_q == '0) && (cnt_b_q == '0)))
    else $error("merge run did not end cleanly");

  // prime is always followed directly by merge
  prime_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRIME) |=> (state_q == ST_MERGE))
    else $error("prime state not followed by merge");

endmodule

[rtl/core/merge_two_sorted_lists.sv]
// Top level of the two-way merge of two sorted lists of signed 32-bit words.
//
//  channel  dir  payload                         accepted when
//  cfg_i    in   list_length (5 bits)            cfg_i.valid && cfg_i.ready
//  in_i     in   list_select, value (s32)        in_i.valid && in_i.ready
//  out_o    out  merged_value (s32), last        out_o.valid && out_o.ready
//
//  Loading takes one input word per cycle; each word is written into its
//  list's RAM at the list's fill count, or dropped if that list is full.
//  The word that fills both lists starts a run: a priming state reads the
//  two heads, then 2*n output words follow, one per cycle, paced by
//  out_o.ready; in_i.ready is low from the filling word until the last word.
//  Each output word of the run compares the two registered RAM heads and
//  advances one read pointer, so the RAM read latency sets the priming gap.
//  Reset (rst_ni, async, active low) clears counts, pointers, the output
//  valid and sets list_length to 16; RAM contents are left as they are.
//  cfg_i is always ready; the output register lets loading go on while
//  the final word of a run still waits.
module merge_two_sorted_lists #(
  parameter int unsigned MAX_LIST = mtsl_pkg::MaxListDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtsl_stream_if.sink   cfg_i,
  mtsl_stream_if.sink   in_i,
  mtsl_stream_if.source out_o
);
  import mtsl_pkg::*;

  localparam int unsigned AW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

  logic          a_we, b_we;
  logic [AW-1:0] waddr_a, waddr_b, raddr_a, raddr_b;
  val_t          wdata, rdata_a, rdata_b;

  mtsl_ctrl #(
    .MAX_LIST (MAX_LIST),
    .AW       (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .in_valid_i  (in_i.valid),
    .in_word_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.data),
    .out_ready_i (out_o.ready),
    .a_we_o      (a_we),
    .b_we_o      (b_we),
    .waddr_a_o   (waddr_a),
    .waddr_b_o   (waddr_b),
    .wdata_o     (wdata),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  // first list RAM
  mtsl_store #(
    .DEPTH (MAX_LIST),
    .AW    (AW)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr_a),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  // second list RAM
  mtsl_store #(
    .DEPTH (MAX_LIST),
    .AW    (AW)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr_b),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

endmodule

[verif/tb_merge_two_sorted_lists.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the two-list merge block, with its merge scoreboard.

// Keeps its own copy of both lists, the fill counts and list_length.
// Completes a merge whenever both lists reach the effective length.
class merge_scoreboard;
  localparam int unsigned Depth = mtsl_pkg::MaxListDefault;

  mtsl_pkg::val_t    first_list [Depth];
  mtsl_pkg::val_t    second_list[Depth];
  int unsigned       first_fill;
  int unsigned       second_fill;
  mtsl_pkg::len_t    list_len;
  mtsl_pkg::out_word_t merged_q[$];
  int unsigned       stored_words;
  int unsigned       errors;

  function new();
    first_fill   = 0;
    second_fill  = 0;
    list_len     = mtsl_pkg::LenReset;
    stored_words = 0;
    errors       = 0;
  endfunction

  function void write_length(mtsl_pkg::len_t len);
    list_len = len;
  endfunction

  // zero acts as one, anything above the store depth acts as the depth
  function int unsigned eff_len();
    if (list_len == 0) return 1;
    if (int'(list_len) > int'(Depth)) return Depth;
    return list_len;
  endfunction

  function int unsigned pending();
    return merged_q.size();
  endfunction

  // Note an accepted input word; queues the merged run when both lists are full.
  function void note_input(mtsl_pkg::in_word_t w);
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int unsigned k;
    mtsl_pkg::out_word_t o;
    n = eff_len();
    if (w.list_select == mtsl_pkg::ListFirst) begin
      if (first_fill < n) begin
        first_list[first_fill] = w.value;
        first_fill++;
        stored_words++;
      end
    end else begin
      if (second_fill < n) begin
        second_list[second_fill] = w.value;
        second_fill++;
        stored_words++;
      end
    end
    if (first_fill < n || second_fill < n) return;
    a = 0;
    b = 0;
    k = 0;
    while (a < n || b < n) begin
      // ties go to the second list
      if (a < n && (b >= n || first_list[a] < second_list[b])) begin
        o.merged_value = first_list[a];
        a++;
      end else begin
        o.merged_value = second_list[b];
        b++;
      end
      o.last = (k == 2 * n - 1);
      merged_q.push_back(o);
      k++;
    end
    first_fill  = 0;
    second_fill = 0;
  endfunction

  function void check_result(mtsl_pkg::out_word_t got);
    mtsl_pkg::out_word_t want;
    if (merged_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected output word: expected none, actual value %0d last %0b",
               $time, got.merged_value, got.last);
      return;
    end
    want = merged_q.pop_front();
    if (got.merged_value !== want.merged_value) begin
      errors++;
      $display("%0t: merged_value mismatch: expected %0d, actual %0d",
               $time, want.merged_value, got.merged_value);
    end
    if (got.last !== want.last) begin
      errors++;
      $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
    end
  endfunction
endclass

module tb_merge_two_sorted_lists;
  import mtsl_pkg::*;

  localparam int unsigned MaxList     = MaxListDefault;
  // Cycles allowed after the last expected word before a register write or
  // the end: covers the priming read and the output register.
  localparam int unsigned DrainHold   = 8;
  // No handshake on any channel for this many cycles means a hang. Longest
  // legal quiet stretch is a sender gap plus a receiver stall plus a drain.
  localparam int unsigned QuietLimit  = 1000;
  // Stored (not dropped) words in the random part.
  localparam int unsigned RandomWords = 100;

  logic clk_i;
  logic rst_ni;

  mtsl_stream_if #(.T(len_t))      cfg_if ();
  mtsl_stream_if #(.T(in_word_t))  in_if ();
  mtsl_stream_if #(.T(out_word_t)) out_if ();

  merge_two_sorted_lists #(
    .MAX_LIST(MaxList)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  merge_scoreboard sb = new();

  bit          steady_feed;   // no sender gaps in this phase
  int unsigned quiet_cycles;

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Monitor: every channel is sampled at the rising edge, before the block's
  // registers update, so the result does not depend on event order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_length(cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog expired with %0d merged words outstanding",
                 $time, sb.pending());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: ready runs of random length broken by stalls; some runs are
  // long enough to cover whole merged runs with no back-pressure.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      int unsigned stall;
      stall = idle_gap();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  // One word into in_i. valid stays high afterwards so back-to-back words
  // need no low cycle; a gap lowers it first.
  task automatic send_word(input logic sel, input val_t v);
    int unsigned gap;
    gap = steady_feed ? 0 : idle_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{list_select: sel, value: v};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Stop feeding until every predicted word is out, then let the block settle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainHold) @(posedge clk_i);
  endtask

  // list_length write; caller makes sure the block is idle.
  task automatic write_length(input len_t len);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= len;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic val_t rand_value(input int unsigned mode);
    val_t corners[6];
    corners = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0001, 32'sh7fff_fffe, 0, -1};
    case (mode)
      0:       return val_t'($urandom);
      1:       return val_t'(int'($urandom_range(0, 8)) - 4);      // dense: many ties
      2:       return val_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return corners[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic len_t pick_length();
    len_t odd_lens[6];
    odd_lens = '{len_t'(0), len_t'(1), len_t'(16), len_t'(31), len_t'(17), len_t'(8)};
    if ($urandom_range(0, 9) == 0) return odd_lens[$urandom_range(0, 5)];
    return len_t'($urandom_range(1, 5));
  endfunction

  // One pair of lists of n words each, interleaved at random. A noisy set may
  // be unsorted, carry stray words (dropped when their list is full) or stop
  // part way, leaving a partial load for the next phase.
  task automatic load_lists(input int unsigned n, input bit noisy);
    val_t        firsts[$];
    val_t        seconds[$];
    int unsigned mode;
    int unsigned cut;
    int unsigned sent;
    logic        sel;
    mode = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++) begin
      firsts.push_back(rand_value(mode));
      seconds.push_back(rand_value(mode));
    end
    if (!noisy || $urandom_range(0, 1) == 0) begin
      firsts.sort();
      seconds.sort();
    end
    cut  = (noisy && $urandom_range(0, 2) == 0) ? $urandom_range(0, 2 * n - 1) : 2 * n;
    sent = 0;
    while ((firsts.size() != 0 || seconds.size() != 0) && sent < cut) begin
      if (noisy && $urandom_range(0, 4) == 0) begin
        send_word(logic'($urandom_range(0, 1)), val_t'($urandom));
      end
      if (firsts.size() == 0)       sel = ListSecond;
      else if (seconds.size() == 0) sel = ListFirst;
      else                          sel = logic'($urandom_range(0, 1));
      if (sel == ListFirst) send_word(ListFirst, firsts.pop_front());
      else                  send_word(ListSecond, seconds.pop_front());
      sent++;
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase;
    int unsigned sets;
    len_t        len;

    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    steady_feed  = 1'b0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // Length zero behaves as one. Full-scale extremes; the second word to
    // the first list finds it full and is dropped.
    write_length(len_t'(0));
    send_word(ListFirst, 32'sh7fff_ffff);
    send_word(ListFirst, 5);
    send_word(ListSecond, 32'sh8000_0000);
    // equal heads: second list's word goes first (same value either way)
    send_word(ListFirst, -1);
    send_word(ListSecond, -1);
    send_word(ListSecond, 32'sh7fff_ffff);
    send_word(ListFirst, 32'sh8000_0000);

    // Length lowered while partly loaded: both lists become full, and the
    // next word (dropped, its list is full) releases the merge.
    wait_drained();
    write_length(len_t'(3));
    send_word(ListFirst, 1);
    send_word(ListFirst, 2);
    send_word(ListSecond, 1);
    send_word(ListSecond, 2);
    wait_drained();
    write_length(len_t'(2));
    send_word(ListSecond, 99);

    // Length raised while partly loaded: the earlier word stays first.
    wait_drained();
    send_word(ListFirst, -3);
    wait_drained();
    write_length(len_t'(4));
    send_word(ListFirst, -2);
    send_word(ListSecond, -10);
    send_word(ListFirst, 7);
    send_word(ListSecond, 0);
    send_word(ListSecond, 8);
    send_word(ListFirst, 8);
    send_word(ListSecond, 100);

    // ---- random part ----
    // Each phase waits for the block to drain, writes a new length (the
    // first two phases take the full store and the oversize value), then
    // runs a few sets. Long lengths get one set only.
    target = sb.stored_words + RandomWords;
    phase  = 0;
    while (sb.stored_words < target) begin
      wait_drained();
      case (phase)
        0:       len = len_t'(16);
        1:       len = len_t'(31);
        default: len = pick_length();
      endcase
      write_length(len);
      steady_feed = ($urandom_range(0, 3) == 0);
      sets = (sb.eff_len() >= 8) ? 1 : $urandom_range(1, 3);
      repeat (sets) begin
        load_lists(sb.eff_len(), $urandom_range(0, 4) == 0);
        // now and then the sender holds off until the merged run has fully drained
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mtsl_pkg.sv
rtl/core/mtsl_stream_if.sv
rtl/core/mtsl_store.sv
rtl/core/mtsl_ctrl.sv
rtl/core/merge_two_sorted_lists.sv
verif/tb_merge_two_sorted_lists.sv
